@@ src/skt_pkg.sv @@
package skt_pkg;

  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned HANDLE_BITS = 5;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_e;

  // command broadcast to every cell
  typedef struct packed {
    logic cmp;  // capture compare flags
    logic ins;  // open a slot at the boundary
    logic del;  // close the slot at the boundary
  } cell_cmd_t;

endpackage

@@ src/skt_cell.sv @@
module skt_cell #(
  parameter int unsigned KEY_BITS = 18
) (
  input  logic                            clk_i,
  input  skt_pkg::cell_cmd_t              cmd_i,
  input  logic                            valid_i,
  input  logic [KEY_BITS-1:0]             key_i,
  input  logic [skt_pkg::HANDLE_BITS-1:0] handle_i,
  input  logic [KEY_BITS-1:0]             left_key_i,
  input  logic [skt_pkg::HANDLE_BITS-1:0] left_handle_i,
  input  logic                            left_lt_i,
  input  logic [KEY_BITS-1:0]             right_key_i,
  input  logic [skt_pkg::HANDLE_BITS-1:0] right_handle_i,
  output logic [KEY_BITS-1:0]             key_o,
  output logic [skt_pkg::HANDLE_BITS-1:0] handle_o,
  output logic                            lt_o,
  output logic                            bound_o,
  output logic                            hit_o
);
  import skt_pkg::*;

  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   lt_q;
  logic                   eq_q;

  // first cell at or above the key, its left neighbor is below it
  assign bound_o  = !lt_q && left_lt_i;
  assign hit_o    = bound_o && eq_q;
  assign lt_o     = lt_q;
  assign key_o    = key_q;
  assign handle_o = handle_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      lt_q <= valid_i && (key_q < key_i);
      eq_q <= valid_i && (key_q == key_i);
    end
    if (cmd_i.ins) begin
      if (bound_o) begin
        key_q    <= key_i;
        handle_q <= handle_i;
      end else if (!lt_q) begin
        key_q    <= left_key_i;
        handle_q <= left_handle_i;
      end
    end else if (cmd_i.del) begin
      if (!lt_q) begin
        key_q    <= right_key_i;
        handle_q <= right_handle_i;
      end
    end
  end

endmodule

@@ src/sorted_key_table_top.sv @@
// sorted key table: up to DEPTH (key, handle) entries kept in ascending key order
// in a row of cells, each cell holding one entry and trading it with its neighbors
// input channel (in_valid_i / in_ready_o): op_i, key_i, handle_i; insert, delete or
//   lookup, code three acts as a lookup
// output channel (out_valid_o / out_ready_i): found_o, handle_out_o, position_o,
//   entry_total_o, status_o; one result transaction per input transaction
// an item is taken in idle, every cell compares its key against it in the next
//   cycle, and in the cycle after that the boundary cell is located; once the
//   output register is free the result is registered and the row shifts by one
//   slot for insert or delete; the next item is taken only after the previous one
//   has finished this accept / compare / shift sequence
// position is the lower bound: the first cell whose key is not less than key_i
// a finished result waits in the output register while the next item is taken
//   and compared; the shift step holds until the output register is free
// reset clears the entry count and the handshake state; cell contents are only
//   meaningful below the entry count and need no clearing
module sorted_key_table_top #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned KEY_BITS = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [skt_pkg::OP_BITS-1:0]         op_i,
  input  logic [KEY_BITS-1:0]                 key_i,
  input  logic [skt_pkg::HANDLE_BITS-1:0]     handle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic [skt_pkg::HANDLE_BITS-1:0]     handle_out_o,
  output logic [$clog2(DEPTH+1)-1:0]          position_o,
  output logic [$clog2(DEPTH+1)-1:0]          entry_total_o,
  output logic [skt_pkg::STATUS_BITS-1:0]     status_o
);
  import skt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  // latched transaction
  logic [OP_BITS-1:0]     op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;

  logic [CW-1:0] count_q, count_d;

  // output register
  logic                   out_valid_q;
  logic                   found_q;
  logic [HANDLE_BITS-1:0] hout_q;
  logic [CW-1:0]          pos_q;
  logic [CW-1:0]          total_q;
  logic [STATUS_BITS-1:0] status_q;

  logic      in_fire;
  logic      exec_fire;
  cell_cmd_t cmd;

  // per-cell buses
  logic [DEPTH-1:0][KEY_BITS-1:0]    cell_key;
  logic [DEPTH-1:0][HANDLE_BITS-1:0] cell_handle;
  logic [DEPTH-1:0]                  cell_lt;
  logic [DEPTH-1:0]                  cell_bound;
  logic [DEPTH-1:0]                  cell_hit;
  logic [DEPTH-1:0]                  cell_valid;

  // reduced results
  logic                   hit_any;
  logic                   bound_any;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [CW-1:0]          bound_pos;
  logic [CW-1:0]          lower_pos;
  logic                   full;
  logic                   is_insert;
  logic                   is_delete;

  assign in_fire   = in_valid_i && in_ready_o;
  assign full      = (count_q == CW'(DEPTH));
  assign is_insert = (op_q == OP_INSERT);
  assign is_delete = (op_q == OP_DELETE);

  // row of cells, each sees its left and right neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]    lkey, rkey;
    logic [HANDLE_BITS-1:0] lhandle, rhandle;
    logic                   llt;

    assign cell_valid[g] = (CW'(g) < count_q);

    if (g == 0) begin : g_first
      assign lkey    = cell_key[g];
      assign lhandle = cell_handle[g];
      assign llt     = 1'b1;
    end else begin : g_mid
      assign lkey    = cell_key[g-1];
      assign lhandle = cell_handle[g-1];
      assign llt     = cell_lt[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rkey    = cell_key[g];
      assign rhandle = cell_handle[g];
    end else begin : g_inner
      assign rkey    = cell_key[g+1];
      assign rhandle = cell_handle[g+1];
    end

    skt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .valid_i       (cell_valid[g]),
      .key_i         (key_q),
      .handle_i      (handle_q),
      .left_key_i    (lkey),
      .left_handle_i (lhandle),
      .left_lt_i     (llt),
      .right_key_i   (rkey),
      .right_handle_i(rhandle),
      .key_o         (cell_key[g]),
      .handle_o      (cell_handle[g]),
      .lt_o          (cell_lt[g]),
      .bound_o       (cell_bound[g]),
      .hit_o         (cell_hit[g])
    );
  end

  // at most one boundary cell, so plain or-reductions pick its data
  always_comb begin
    hit_handle = '0;
    bound_pos  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_hit[i]) hit_handle = hit_handle | cell_handle[i];
      if (cell_bound[i]) bound_pos = bound_pos | CW'(i);
    end
  end

  assign hit_any   = |cell_hit;
  assign bound_any = |cell_bound;
  // every held key below the new one: lower bound is the end of a full row
  assign lower_pos = bound_any ? bound_pos : CW'(DEPTH);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CMP;
      ST_CMP:  state_d = ST_EXEC;
      ST_EXEC: if (exec_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    exec_fire  = 1'b0;
    cmd        = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CMP:  cmd.cmp = 1'b1;
      ST_EXEC: begin
        exec_fire = !out_valid_q || out_ready_i;
        cmd.ins   = exec_fire && is_insert && !full;
        cmd.del   = exec_fire && is_delete && hit_any;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) count_d = count_q + CW'(1);
    else if (cmd.del) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (exec_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_i;
      key_q    <= key_i;
      handle_q <= handle_i;
    end
    if (exec_fire) begin
      pos_q   <= lower_pos;
      total_q <= count_d;
      if (is_insert) begin
        found_q  <= 1'b0;
        hout_q   <= '0;
        status_q <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        // delete, lookup and the unused code all report the match
        found_q  <= hit_any;
        hout_q   <= hit_handle;
        status_q <= hit_any ? STATUS_OK : STATUS_NOT_FOUND;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign handle_out_o  = hout_q;
  assign position_o    = pos_q;
  assign entry_total_o = total_q;
  assign status_o      = status_q;

endmodule
